// ===== hdl/two_level_write_back_cache_assert.svh =====
// assertion macros for the two-level write-back cache
// used by the top level; expects clk and arst_n in scope
`ifndef TWO_LEVEL_WRITE_BACK_CACHE_ASSERT_SVH
`define TWO_LEVEL_WRITE_BACK_CACHE_ASSERT_SVH

// same-cycle implication
`define TLWBC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TLWBC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/tlwbc_pkg.sv =====
// shared types and constants of the two-level write-back cache
// no dependencies
package tlwbc_pkg;

	localparam int ADDR_W    = 8;
	localparam int DATA_W    = 32;
	localparam int LAT_W     = 8;
	localparam int MEM_WORDS = 256;

	// first level geometry
	localparam int NEAR_SETS  = 4;
	localparam int NEAR_WAYS  = 2;
	localparam int NEAR_WORDS = 4;
	localparam int N_OFF_W    = $clog2(NEAR_WORDS);
	localparam int N_SET_W    = $clog2(NEAR_SETS);
	localparam int N_WAY_W    = $clog2(NEAR_WAYS);
	localparam int N_TAG_W    = ADDR_W - N_OFF_W - N_SET_W;
	localparam int N_LINES    = NEAR_SETS * NEAR_WAYS;
	localparam int N_LINE_W   = $clog2(N_LINES);
	localparam int N_DEPTH    = N_LINES * NEAR_WORDS;
	localparam int N_RAM_AW   = $clog2(N_DEPTH);

	// second level geometry
	localparam int FAR_SETS  = 8;
	localparam int FAR_WAYS  = 4;
	localparam int FAR_WORDS = 8;
	localparam int F_OFF_W   = $clog2(FAR_WORDS);
	localparam int F_SET_W   = $clog2(FAR_SETS);
	localparam int F_WAY_W   = $clog2(FAR_WAYS);
	localparam int F_TAG_W   = ADDR_W - F_OFF_W - F_SET_W;
	localparam int F_LINES   = FAR_SETS * FAR_WAYS;
	localparam int F_LINE_W  = $clog2(F_LINES);
	localparam int F_DEPTH   = F_LINES * FAR_WORDS;
	localparam int F_RAM_AW  = $clog2(F_DEPTH);

	// victim buffer holds one line of either level
	localparam int BUF_WORDS = FAR_WORDS;
	localparam int BUF_AW    = $clog2(BUF_WORDS);
	localparam int CNT_W     = $clog2(BUF_WORDS + 1);

	// word-index masks inside a line or memory
	localparam logic [ADDR_W-1:0] NEAR_MASK = ADDR_W'(NEAR_WORDS - 1);
	localparam logic [ADDR_W-1:0] FAR_MASK  = ADDR_W'(FAR_WORDS - 1);
	localparam logic [ADDR_W-1:0] BUF_MASK  = ADDR_W'(BUF_WORDS - 1);
	localparam logic [ADDR_W-1:0] MEM_MASK  = ADDR_W'(MEM_WORDS - 1);

	// operation codes
	localparam logic [1:0] OP_WRITE     = 2'd1;
	localparam int         OP_FLUSH_BIT = 1;

	// served_by codes
	localparam logic [1:0] SRV_NEAR  = 2'd0;
	localparam logic [1:0] SRV_FAR   = 2'd1;
	localparam logic [1:0] SRV_MEM   = 2'd2;
	localparam logic [1:0] SRV_FLUSH = 2'd3;

	// configuration register indexes and reset values
	localparam int               CFG_IDX_W   = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_L1_LAT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_L2_LAT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEM_LAT = 2'd2;
	localparam logic [LAT_W-1:0] L1_LAT_RST  = 8'd1;
	localparam logic [LAT_W-1:0] L2_LAT_RST  = 8'd10;
	localparam logic [LAT_W-1:0] MEM_LAT_RST = 8'd100;

	typedef struct packed {
		logic [1:0]               operation;
		logic [ADDR_W-1:0]        word_address;
		logic signed [DATA_W-1:0] write_data;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_data;
		logic [1:0]               served_by;
		logic [LAT_W-1:0]         service_cycles;
	} rsp_t;

endpackage

// ===== hdl/two_level_write_back_cache.sv =====
// Two-level write-back cache over a 256-word main memory.
// Request channel req (req_valid / req_stall): read, write or flush items.
// Response channel rsp (rsp_valid / rsp_stall): one item per request with the
// read word, the serving level and its latency register (zero on flush).
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 first level latency, 1 second level latency, 2 memory latency).
// After reset the main memory is cleared one word a cycle while req_stall
// stays high; configuration writes are taken meanwhile.
// Items are handled one at a time by a sequencer around three memories
// (first level data, second level data, main memory); line moves go
// through a copy engine that reads one word a cycle and writes each from its registered read.
// Cost per item grows from a first level hit over a second level hit to a
// miss in both levels; dirty victims add line write-backs, and a flush
// walks every far line, then every near line, writing back dirty ones.
// A finished result sits in the output register until taken; the next
// item is accepted meanwhile, but its result waits while rsp_stall is high.
`include "two_level_write_back_cache_assert.svh"

module two_level_write_back_cache
	import tlwbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LAT_W-1:0]     cfg_data
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_LOOK, S_NRD, S_FRD, S_NSEL, S_NFILL, S_NMETA, S_NVOUT,
		S_FSEL, S_FFILL, S_FMETA, S_MRD, S_MWAIT, S_FLCHK, S_FLADV, S_COPY, S_RESP
	} state_t;

	typedef enum logic [1:0] {PT_NEAR, PT_FAR, PT_MEM, PT_BUF} port_t;

	typedef logic [NEAR_WAYS-1:0][N_WAY_W-1:0] n_rank_row_t;
	typedef logic [FAR_WAYS-1:0][F_WAY_W-1:0]  f_rank_row_t;

	// victim choice: first free way, else oldest
	function automatic logic [N_WAY_W-1:0] near_victim(logic [NEAR_WAYS-1:0] vl,
		n_rank_row_t rk);
		logic found;
		logic [N_WAY_W-1:0] way;
		found = 1'b0;
		way = '0;
		for (int w = 0; w < NEAR_WAYS; w++) begin
			if (!found && !vl[w]) begin
				way = N_WAY_W'(w);
				found = 1'b1;
			end
		end
		if (!found) begin
			for (int w = 1; w < NEAR_WAYS; w++) begin
				if (rk[w] > rk[way]) way = N_WAY_W'(w);
			end
		end
		return way;
	endfunction

	function automatic logic [F_WAY_W-1:0] far_victim(logic [FAR_WAYS-1:0] vl,
		f_rank_row_t rk);
		logic found;
		logic [F_WAY_W-1:0] way;
		found = 1'b0;
		way = '0;
		for (int w = 0; w < FAR_WAYS; w++) begin
			if (!found && !vl[w]) begin
				way = F_WAY_W'(w);
				found = 1'b1;
			end
		end
		if (!found) begin
			for (int w = 1; w < FAR_WAYS; w++) begin
				if (rk[w] > rk[way]) way = F_WAY_W'(w);
			end
		end
		return way;
	endfunction

	// lru update: used way goes to rank zero; younger valid ways age, all valid ones if it was empty
	function automatic n_rank_row_t near_touch(n_rank_row_t rk, logic [NEAR_WAYS-1:0] vl,
		logic [N_WAY_W-1:0] way, logic was_valid);
		n_rank_row_t res;
		res = rk;
		for (int v = 0; v < NEAR_WAYS; v++) begin
			if (N_WAY_W'(v) != way && vl[v] && (!was_valid || rk[v] < rk[way]))
				res[v] = rk[v] + 1'b1;
		end
		res[way] = '0;
		return res;
	endfunction

	function automatic f_rank_row_t far_touch(f_rank_row_t rk, logic [FAR_WAYS-1:0] vl,
		logic [F_WAY_W-1:0] way, logic was_valid);
		f_rank_row_t res;
		res = rk;
		for (int v = 0; v < FAR_WAYS; v++) begin
			if (F_WAY_W'(v) != way && vl[v] && (!was_valid || rk[v] < rk[way]))
				res[v] = rk[v] + 1'b1;
		end
		res[way] = '0;
		return res;
	endfunction

	// word address of word k inside a wrapping window
	function automatic logic [ADDR_W-1:0] win_addr(logic [ADDR_W-1:0] start,
		logic [ADDR_W-1:0] mask, logic [CNT_W-1:0] k);
		return (start & ~mask) | ((start + ADDR_W'(k)) & mask);
	endfunction

	state_t state_q, ret_q;
	req_t   req_q;
	rsp_t   rsp_q;
	logic   out_valid_q;
	logic [LAT_W-1:0] l1_lat_q, l2_lat_q, mem_lat_q;
	logic [ADDR_W-1:0] clr_q;

	// level metadata
	logic [NEAR_SETS-1:0][NEAR_WAYS-1:0][N_TAG_W-1:0] near_tag_q;
	logic [NEAR_SETS-1:0][NEAR_WAYS-1:0]              near_valid_q, near_dirty_q;
	n_rank_row_t [NEAR_SETS-1:0]                      near_rank_q;
	logic [FAR_SETS-1:0][FAR_WAYS-1:0][F_TAG_W-1:0]   far_tag_q;
	logic [FAR_SETS-1:0][FAR_WAYS-1:0]                far_valid_q, far_dirty_q;
	f_rank_row_t [FAR_SETS-1:0]                       far_rank_q;

	// request progress
	logic [DATA_W-1:0]   rd_q;
	logic [1:0]          served_q;
	logic                miss_q;
	logic [F_LINE_W-1:0] fln_q;
	logic [N_WAY_W-1:0]  nv_way_q;
	logic                nwas_q, nvd_q;
	logic [ADDR_W-1:0]   nva_q;
	logic [F_WAY_W-1:0]  fv_way_q;
	logic                fwas_q, fvd_q;
	logic [ADDR_W-1:0]   fva_q;
	logic                fl_far_q;
	logic [F_LINE_W-1:0] fl_line_q;

	// copy engine
	port_t             cp_src_q, cp_dst_q;
	logic [ADDR_W-1:0] cp_sstart_q, cp_smask_q, cp_dstart_q, cp_dmask_q;
	logic [CNT_W-1:0]  cp_cnt_q, cp_ri_q, cp_wi_s1;
	logic              cp_v_s1;
	logic [DATA_W-1:0] buf_q [BUF_WORDS];
	logic [DATA_W-1:0] buf_rd_q;

	// copy start request from the sequencer
	logic              cp_start;
	port_t             cp_src, cp_dst;
	logic [ADDR_W-1:0] cp_sstart, cp_smask, cp_dstart, cp_dmask;
	logic [CNT_W-1:0]  cp_cnt;
	state_t            cp_ret;

	// ram ports
	logic                n_we, f_we, m_we;
	logic [N_RAM_AW-1:0] n_waddr, n_raddr;
	logic [F_RAM_AW-1:0] f_waddr, f_raddr;
	logic [ADDR_W-1:0]   m_waddr, m_raddr;
	logic [DATA_W-1:0]   n_wdata, f_wdata, m_wdata;
	logic [DATA_W-1:0]   n_rdata, f_rdata, m_rdata;

	// decoded request
	logic [ADDR_W-1:0]  a, f_la, cp_raddr, cp_waddr;
	logic [N_SET_W-1:0] n_set;
	logic [N_TAG_W-1:0] n_tag;
	logic [N_OFF_W-1:0] n_off;
	logic [F_SET_W-1:0] f_set;
	logic [F_TAG_W-1:0] f_tag;
	logic [F_OFF_W-1:0] f_off;
	logic               is_flush, is_wr;
	logic [NEAR_WAYS-1:0] n_hit_vec;
	logic [FAR_WAYS-1:0]  f_hit_vec;
	logic               n_hit, f_hit;
	logic [N_WAY_W-1:0] n_hit_way, n_vict, n_touch_way;
	logic [F_WAY_W-1:0] f_hit_way, f_vict, f_touch_way;
	logic               n_touch_was, f_touch_was;
	n_rank_row_t        n_touch;
	f_rank_row_t        f_touch;
	logic [DATA_W-1:0]  cp_src_data;
	logic [F_SET_W-1:0] fl_fset;
	logic [F_WAY_W-1:0] fl_fway;
	logic [N_SET_W-1:0] fl_nset;
	logic [N_WAY_W-1:0] fl_nway;
	logic [LAT_W-1:0]   lat_sel;
	logic               rsp_load;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	// result register loads when empty or being taken
	assign rsp_load = (state_q == S_RESP) && (!out_valid_q || !rsp_stall);

	// request decode
	assign a        = req_q.word_address;
	assign is_flush = req_q.operation[OP_FLUSH_BIT];
	assign is_wr    = (req_q.operation == OP_WRITE);
	assign n_off    = a[N_OFF_W-1:0];
	assign n_set    = a[N_OFF_W +: N_SET_W];
	assign n_tag    = a[ADDR_W-1 -: N_TAG_W];
	assign f_la     = (state_q == S_NVOUT) ? nva_q : a;
	assign f_off    = f_la[F_OFF_W-1:0];
	assign f_set    = f_la[F_OFF_W +: F_SET_W];
	assign f_tag    = f_la[ADDR_W-1 -: F_TAG_W];

	assign fl_fset = fl_line_q[F_LINE_W-1:F_WAY_W];
	assign fl_fway = fl_line_q[F_WAY_W-1:0];
	assign fl_nset = fl_line_q[N_LINE_W-1:N_WAY_W];
	assign fl_nway = fl_line_q[N_WAY_W-1:0];

	// tag compare of both levels
	always_comb begin
		n_hit_way = '0;
		f_hit_way = '0;
		for (int w = 0; w < NEAR_WAYS; w++)
			n_hit_vec[w] = near_valid_q[n_set][w] && (near_tag_q[n_set][w] == n_tag);
		for (int w = 0; w < FAR_WAYS; w++)
			f_hit_vec[w] = far_valid_q[f_set][w] && (far_tag_q[f_set][w] == f_tag);
		for (int w = NEAR_WAYS - 1; w >= 0; w--)
			if (n_hit_vec[w]) n_hit_way = N_WAY_W'(w);
		for (int w = FAR_WAYS - 1; w >= 0; w--)
			if (f_hit_vec[w]) f_hit_way = F_WAY_W'(w);
	end
	assign n_hit = |n_hit_vec;
	assign f_hit = |f_hit_vec;

	// replacement and lru updates
	assign n_vict      = near_victim(near_valid_q[n_set], near_rank_q[n_set]);
	assign f_vict      = far_victim(far_valid_q[f_set], far_rank_q[f_set]);
	assign n_touch_way = (state_q == S_NMETA) ? nv_way_q : n_hit_way;
	assign n_touch_was = (state_q == S_NMETA) ? nwas_q : 1'b1;
	assign f_touch_way = (state_q == S_FMETA) ? fv_way_q : f_hit_way;
	assign f_touch_was = (state_q == S_FMETA) ? fwas_q : 1'b1;
	assign n_touch = near_touch(near_rank_q[n_set], near_valid_q[n_set], n_touch_way,
		n_touch_was);
	assign f_touch = far_touch(far_rank_q[f_set], far_valid_q[f_set], f_touch_way,
		f_touch_was);

	// copy engine addresses and source data
	assign cp_raddr = win_addr(cp_sstart_q, cp_smask_q, cp_ri_q);
	assign cp_waddr = win_addr(cp_dstart_q, cp_dmask_q, cp_wi_s1);

	always_comb begin
		unique case (cp_src_q)
			PT_NEAR: cp_src_data = n_rdata;
			PT_FAR:  cp_src_data = f_rdata;
			PT_MEM:  cp_src_data = m_rdata;
			PT_BUF:  cp_src_data = buf_rd_q;
			default: cp_src_data = buf_rd_q;
		endcase
	end

	// line moves started by the sequencer
	always_comb begin
		cp_start  = 1'b0;
		cp_src    = PT_BUF;
		cp_dst    = PT_BUF;
		cp_sstart = '0;
		cp_smask  = BUF_MASK;
		cp_dstart = '0;
		cp_dmask  = BUF_MASK;
		cp_cnt    = CNT_W'(NEAR_WORDS);
		cp_ret    = S_IDLE;
		unique case (state_q)
			S_NSEL: begin
				cp_start  = near_valid_q[n_set][n_vict] && near_dirty_q[n_set][n_vict];
				cp_src    = PT_NEAR;
				cp_sstart = ADDR_W'({n_set, n_vict, {N_OFF_W{1'b0}}});
				cp_smask  = NEAR_MASK;
				cp_ret    = S_NFILL;
			end
			S_NFILL: begin
				cp_start  = 1'b1;
				cp_src    = miss_q ? PT_MEM : PT_FAR;
				cp_sstart = miss_q ? {a[ADDR_W-1:N_OFF_W], {N_OFF_W{1'b0}}}
					: ADDR_W'({fln_q, a[F_OFF_W-1:N_OFF_W], {N_OFF_W{1'b0}}});
				cp_smask  = miss_q ? MEM_MASK : FAR_MASK;
				cp_dst    = PT_NEAR;
				cp_dstart = ADDR_W'({n_set, nv_way_q, {N_OFF_W{1'b0}}});
				cp_dmask  = NEAR_MASK;
				cp_ret    = S_NMETA;
			end
			S_NVOUT: begin
				cp_start  = 1'b1;
				cp_dst    = f_hit ? PT_FAR : PT_MEM;
				cp_dstart = f_hit ? ADDR_W'({f_set, f_hit_way, f_off}) : nva_q;
				cp_dmask  = f_hit ? FAR_MASK : MEM_MASK;
				cp_ret    = miss_q ? S_FSEL : S_RESP;
			end
			S_FSEL: begin
				cp_start  = far_valid_q[f_set][f_vict] && far_dirty_q[f_set][f_vict];
				cp_src    = PT_FAR;
				cp_sstart = ADDR_W'({f_set, f_vict, {F_OFF_W{1'b0}}});
				cp_smask  = FAR_MASK;
				cp_cnt    = CNT_W'(FAR_WORDS);
				cp_ret    = S_FFILL;
			end
			S_FFILL: begin
				cp_start  = 1'b1;
				cp_src    = PT_MEM;
				cp_sstart = {a[ADDR_W-1:F_OFF_W], {F_OFF_W{1'b0}}};
				cp_smask  = MEM_MASK;
				cp_dst    = PT_FAR;
				cp_dstart = ADDR_W'({f_set, fv_way_q, {F_OFF_W{1'b0}}});
				cp_dmask  = FAR_MASK;
				cp_cnt    = CNT_W'(FAR_WORDS);
				cp_ret    = S_FMETA;
			end
			S_FMETA: begin
				cp_start  = fvd_q;
				cp_dst    = PT_MEM;
				cp_dstart = fva_q;
				cp_dmask  = MEM_MASK;
				cp_cnt    = CNT_W'(FAR_WORDS);
				cp_ret    = S_MRD;
			end
			S_FLCHK: begin
				cp_dst   = PT_MEM;
				cp_dmask = MEM_MASK;
				cp_ret   = S_FLADV;
				if (fl_far_q) begin
					cp_start  = far_valid_q[fl_fset][fl_fway] && far_dirty_q[fl_fset][fl_fway];
					cp_src    = PT_FAR;
					cp_sstart = ADDR_W'({fl_line_q, {F_OFF_W{1'b0}}});
					cp_smask  = FAR_MASK;
					cp_dstart = {far_tag_q[fl_fset][fl_fway], fl_fset, {F_OFF_W{1'b0}}};
					cp_cnt    = CNT_W'(FAR_WORDS);
				end else begin
					cp_start  = near_valid_q[fl_nset][fl_nway] && near_dirty_q[fl_nset][fl_nway];
					cp_src    = PT_NEAR;
					cp_sstart = ADDR_W'({fl_line_q[N_LINE_W-1:0], {N_OFF_W{1'b0}}});
					cp_smask  = NEAR_MASK;
					cp_dstart = {near_tag_q[fl_nset][fl_nway], fl_nset, {N_OFF_W{1'b0}}};
				end
			end
			default: cp_start = 1'b0;
		endcase
	end

	// ram port steering
	always_comb begin
		n_we    = 1'b0;
		n_waddr = {n_set, n_hit_way, n_off};
		n_wdata = req_q.write_data;
		n_raddr = {n_set, n_hit_way, n_off};
		f_we    = 1'b0;
		f_waddr = {f_set, f_hit_way, f_off};
		f_wdata = req_q.write_data;
		f_raddr = {f_set, f_hit_way, f_off};
		m_we    = 1'b0;
		m_waddr = a;
		m_wdata = req_q.write_data;
		m_raddr = a;
		if (state_q == S_CLEAR) begin
			m_we    = 1'b1;
			m_waddr = clr_q;
			m_wdata = '0;
		end
		if (state_q == S_LOOK && !is_flush && is_wr) begin
			if (n_hit) n_we = 1'b1;
			else if (f_hit) f_we = 1'b1;
			else m_we = 1'b1;
		end
		if (state_q == S_COPY) begin
			if (cp_src_q == PT_NEAR) n_raddr = cp_raddr[N_RAM_AW-1:0];
			if (cp_src_q == PT_FAR) f_raddr = cp_raddr[F_RAM_AW-1:0];
			if (cp_src_q == PT_MEM) m_raddr = cp_raddr;
			if (cp_v_s1) begin
				unique case (cp_dst_q)
					PT_NEAR: begin
						n_we    = 1'b1;
						n_waddr = cp_waddr[N_RAM_AW-1:0];
						n_wdata = cp_src_data;
					end
					PT_FAR: begin
						f_we    = 1'b1;
						f_waddr = cp_waddr[F_RAM_AW-1:0];
						f_wdata = cp_src_data;
					end
					PT_MEM: begin
						m_we    = 1'b1;
						m_waddr = cp_waddr;
						m_wdata = cp_src_data;
					end
					default: m_we = 1'b0;
				endcase
			end
		end
	end

	tlwbc_ram #(.WIDTH(DATA_W), .DEPTH(N_DEPTH)) u_near_ram (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.raddr(n_raddr), .rdata(n_rdata)
	);

	tlwbc_ram #(.WIDTH(DATA_W), .DEPTH(F_DEPTH)) u_far_ram (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(f_rdata)
	);

	tlwbc_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_main_ram (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata)
	);

	// latency of the serving level
	always_comb begin
		unique case (served_q)
			SRV_NEAR: lat_sel = l1_lat_q;
			SRV_FAR:  lat_sel = l2_lat_q;
			SRV_MEM:  lat_sel = mem_lat_q;
			default:  lat_sel = '0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_lat_q  <= L1_LAT_RST;
			l2_lat_q  <= L2_LAT_RST;
			mem_lat_q <= MEM_LAT_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_L1_LAT) l1_lat_q <= cfg_data;
			if (cfg_index == CFG_L2_LAT) l2_lat_q <= cfg_data;
			if (cfg_index == CFG_MEM_LAT) mem_lat_q <= cfg_data;
		end
	end

	// request capture, tags and victim buffer
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) req_q <= req;
		if (state_q == S_NMETA) near_tag_q[n_set][nv_way_q] <= n_tag;
		if (state_q == S_FMETA) far_tag_q[f_set][fv_way_q] <= f_tag;
		if (state_q == S_COPY && cp_v_s1 && cp_dst_q == PT_BUF)
			buf_q[cp_waddr[BUF_AW-1:0]] <= cp_src_data;
		buf_rd_q <= buf_q[cp_raddr[BUF_AW-1:0]];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			ret_q        <= S_IDLE;
			clr_q        <= '0;
			out_valid_q  <= 1'b0;
			rsp_q        <= '0;
			near_valid_q <= '0;
			near_dirty_q <= '0;
			near_rank_q  <= '0;
			far_valid_q  <= '0;
			far_dirty_q  <= '0;
			far_rank_q   <= '0;
			rd_q         <= '0;
			served_q     <= SRV_NEAR;
			miss_q       <= 1'b0;
			fln_q        <= '0;
			nv_way_q     <= '0;
			nwas_q       <= 1'b0;
			nvd_q        <= 1'b0;
			nva_q        <= '0;
			fv_way_q     <= '0;
			fwas_q       <= 1'b0;
			fvd_q        <= 1'b0;
			fva_q        <= '0;
			fl_far_q     <= 1'b0;
			fl_line_q    <= '0;
			cp_src_q     <= PT_BUF;
			cp_dst_q     <= PT_BUF;
			cp_sstart_q  <= '0;
			cp_smask_q   <= '0;
			cp_dstart_q  <= '0;
			cp_dmask_q   <= '0;
			cp_cnt_q     <= '0;
			cp_ri_q      <= '0;
			cp_wi_s1     <= '0;
			cp_v_s1      <= 1'b0;
		end else begin
			// output register: load a new result or drop a taken one
			if (rsp_load) out_valid_q <= 1'b1;
			else if (!rsp_stall) out_valid_q <= 1'b0;
			// one read a cycle, each write in the cycle after its read
			cp_v_s1 <= (state_q == S_COPY) && (cp_ri_q != cp_cnt_q);
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MEM_MASK) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) state_q <= S_LOOK;
				end
				S_LOOK: begin
					rd_q <= '0;
					if (is_flush) begin
						served_q  <= SRV_FLUSH;
						fl_far_q  <= 1'b1;
						fl_line_q <= '0;
						state_q   <= S_FLCHK;
					end else if (n_hit) begin
						served_q           <= SRV_NEAR;
						near_rank_q[n_set] <= n_touch;
						if (is_wr) begin
							near_dirty_q[n_set][n_hit_way] <= 1'b1;
							state_q <= S_RESP;
						end else begin
							state_q <= S_NRD;
						end
					end else if (f_hit) begin
						served_q          <= SRV_FAR;
						miss_q            <= 1'b0;
						fln_q             <= {f_set, f_hit_way};
						far_rank_q[f_set] <= f_touch;
						if (is_wr) begin
							far_dirty_q[f_set][f_hit_way] <= 1'b1;
							state_q <= S_NSEL;
						end else begin
							state_q <= S_FRD;
						end
					end else begin
						served_q <= SRV_MEM;
						miss_q   <= 1'b1;
						state_q  <= S_NSEL;
					end
				end
				S_NRD: begin
					rd_q    <= n_rdata;
					state_q <= S_RESP;
				end
				S_FRD: begin
					rd_q    <= f_rdata;
					state_q <= S_NSEL;
				end
				S_NSEL: begin
					nv_way_q <= n_vict;
					nwas_q   <= near_valid_q[n_set][n_vict];
					nvd_q    <= near_valid_q[n_set][n_vict] && near_dirty_q[n_set][n_vict];
					nva_q    <= {near_tag_q[n_set][n_vict], n_set, {N_OFF_W{1'b0}}};
					state_q  <= cp_start ? S_COPY : S_NFILL;
				end
				S_NFILL: begin
					state_q <= S_COPY;
				end
				S_NMETA: begin
					near_valid_q[n_set][nv_way_q] <= 1'b1;
					near_dirty_q[n_set][nv_way_q] <= 1'b0;
					near_rank_q[n_set]            <= n_touch;
					if (nvd_q) state_q <= S_NVOUT;
					else if (miss_q) state_q <= S_FSEL;
					else state_q <= S_RESP;
				end
				S_NVOUT: begin
					// victim lands in the far line if that level holds it
					if (f_hit) far_dirty_q[f_set][f_hit_way] <= 1'b1;
					state_q <= S_COPY;
				end
				S_FSEL: begin
					fv_way_q <= f_vict;
					fwas_q   <= far_valid_q[f_set][f_vict];
					fvd_q    <= far_valid_q[f_set][f_vict] && far_dirty_q[f_set][f_vict];
					fva_q    <= {far_tag_q[f_set][f_vict], f_set, {F_OFF_W{1'b0}}};
					state_q  <= cp_start ? S_COPY : S_FFILL;
				end
				S_FFILL: begin
					state_q <= S_COPY;
				end
				S_FMETA: begin
					far_valid_q[f_set][fv_way_q] <= 1'b1;
					far_dirty_q[f_set][fv_way_q] <= 1'b0;
					far_rank_q[f_set]            <= f_touch;
					state_q <= cp_start ? S_COPY : S_MRD;
				end
				S_MRD: begin
					state_q <= is_wr ? S_RESP : S_MWAIT;
				end
				S_MWAIT: begin
					rd_q    <= m_rdata;
					state_q <= S_RESP;
				end
				S_FLCHK: begin
					state_q <= cp_start ? S_COPY : S_FLADV;
				end
				S_FLADV: begin
					// far level first, then near level
					if (fl_far_q) begin
						if (fl_line_q == F_LINE_W'(F_LINES - 1)) begin
							fl_far_q  <= 1'b0;
							fl_line_q <= '0;
						end else begin
							fl_line_q <= fl_line_q + 1'b1;
						end
						state_q <= S_FLCHK;
					end else if (fl_line_q[N_LINE_W-1:0] == N_LINE_W'(N_LINES - 1)) begin
						state_q <= S_RESP;
					end else begin
						fl_line_q <= fl_line_q + 1'b1;
						state_q   <= S_FLCHK;
					end
				end
				S_COPY: begin
					if (cp_ri_q != cp_cnt_q) begin
						cp_ri_q  <= cp_ri_q + 1'b1;
						cp_wi_s1 <= cp_ri_q;
					end else if (cp_v_s1) begin
						state_q <= ret_q;
					end
				end
				S_RESP: begin
					if (rsp_load) begin
						rsp_q.read_data      <= rd_q;
						rsp_q.served_by      <= served_q;
						rsp_q.service_cycles <= lat_sel;
						state_q              <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// a started line move takes over the sequencer
			if (cp_start) begin
				cp_src_q    <= cp_src;
				cp_dst_q    <= cp_dst;
				cp_sstart_q <= cp_sstart;
				cp_smask_q  <= cp_smask;
				cp_dstart_q <= cp_dstart;
				cp_dmask_q  <= cp_dmask;
				cp_cnt_q    <= cp_cnt;
				cp_ri_q     <= '0;
				ret_q       <= cp_ret;
			end
		end
	end

	// checks
	`TLWBC_ASSERT_NXT(a_accept_starts_lookup, req_valid && !req_stall, state_q == S_LOOK, "accepted item did not start a lookup")
	`TLWBC_ASSERT_IMP(a_near_hit_unique, state_q == S_LOOK, $onehot0(n_hit_vec), "near level hits in more than one way")
	`TLWBC_ASSERT_IMP(a_far_hit_unique, state_q == S_LOOK || state_q == S_NVOUT, $onehot0(f_hit_vec), "far level hits in more than one way")
	`TLWBC_ASSERT_IMP(a_copy_bound, state_q == S_COPY, cp_ri_q <= cp_cnt_q, "line move ran past its length")
	`TLWBC_ASSERT_IMP(a_no_result_in_clear, state_q == S_CLEAR, !rsp_valid, "result during memory clear")

endmodule

// ===== hdl/tlwbc_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module tlwbc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== tb/two_level_write_back_cache_tb.sv =====
// testbench for the two-level write-back cache: directed and random items
// checked against a behavioral model of both cache levels and main memory
// depends on tlwbc_pkg and two_level_write_back_cache
`timescale 1ns / 100ps

module two_level_write_back_cache_tb;
	import tlwbc_pkg::*;

	localparam logic [1:0] OP_READ = 2'd0;
	localparam logic [1:0] OP_FLUSH = 2'd2;
	localparam logic [1:0] OP_FLUSH_ALT = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LAT_W-1:0] cfg_data = '0;

	two_level_write_back_cache dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// model state
	logic [DATA_W-1:0] mem_words [MEM_WORDS];
	logic [DATA_W-1:0] n_data [N_LINES][NEAR_WORDS];
	int n_tag [N_LINES];
	bit n_val [N_LINES];
	bit n_dty [N_LINES];
	int n_rank [N_LINES];
	logic [DATA_W-1:0] f_data [F_LINES][FAR_WORDS];
	int f_tag [F_LINES];
	bit f_val [F_LINES];
	bit f_dty [F_LINES];
	int f_rank [F_LINES];
	logic [LAT_W-1:0] lat_near = L1_LAT_RST, lat_far = L2_LAT_RST, lat_mem = MEM_LAT_RST;

	rsp_t expected_rsps [$];
	int errors = 0;
	int sent = 0;
	int got = 0;
	int srv_count [4];

	// lookups, -1 on miss
	function automatic int near_find(int a);
		int s;
		s = (a / NEAR_WORDS) % NEAR_SETS;
		for (int w = 0; w < NEAR_WAYS; w++)
			if (n_val[s*NEAR_WAYS+w] && n_tag[s*NEAR_WAYS+w] == a / (NEAR_WORDS*NEAR_SETS))
				return w;
		return -1;
	endfunction

	function automatic int far_find(int a);
		int s;
		s = (a / FAR_WORDS) % FAR_SETS;
		for (int w = 0; w < FAR_WAYS; w++)
			if (f_val[s*FAR_WAYS+w] && f_tag[s*FAR_WAYS+w] == a / (FAR_WORDS*FAR_SETS))
				return w;
		return -1;
	endfunction

	// lru rank update, rank 0 is most recent
	function automatic void near_touch(int s, int way, bit was_valid);
		int b, r;
		b = s * NEAR_WAYS;
		r = n_rank[b+way];
		for (int v = 0; v < NEAR_WAYS; v++)
			if (v != way && n_val[b+v] && (!was_valid || n_rank[b+v] < r))
				n_rank[b+v]++;
		n_rank[b+way] = 0;
	endfunction

	function automatic void far_touch(int s, int way, bit was_valid);
		int b, r;
		b = s * FAR_WAYS;
		r = f_rank[b+way];
		for (int v = 0; v < FAR_WAYS; v++)
			if (v != way && f_val[b+v] && (!was_valid || f_rank[b+v] < r))
				f_rank[b+v]++;
		f_rank[b+way] = 0;
	endfunction

	// pick a victim way: first free, else highest rank
	function automatic int pick_way(int b, int ways, bit is_near);
		int way;
		way = 0;
		for (int w = 0; w < ways; w++)
			if (!(is_near ? n_val[b+w] : f_val[b+w]))
				return w;
		for (int w = 1; w < ways; w++)
			if ((is_near ? n_rank[b+w] : f_rank[b+w]) > (is_near ? n_rank[b+way] : f_rank[b+way]))
				way = w;
		return way;
	endfunction

	// fill the near level; a dirty victim goes to the far level or memory
	function automatic void near_fill(int a, logic [DATA_W-1:0] blk [NEAR_WORDS]);
		int s, b, way, ln, va, fw, fln;
		bit was_valid;
		logic [DATA_W-1:0] vb [NEAR_WORDS];
		s = (a / NEAR_WORDS) % NEAR_SETS;
		b = s * NEAR_WAYS;
		way = pick_way(b, NEAR_WAYS, 1'b1);
		ln = b + way;
		was_valid = n_val[ln];
		if (was_valid && n_dty[ln]) begin
			va = n_tag[ln] * NEAR_WORDS * NEAR_SETS + s * NEAR_WORDS;
			vb = n_data[ln];
			fw = far_find(va);
			if (fw >= 0) begin
				fln = ((va / FAR_WORDS) % FAR_SETS) * FAR_WAYS + fw;
				for (int i = 0; i < NEAR_WORDS; i++)
					f_data[fln][(va + i) % FAR_WORDS] = vb[i];
				f_dty[fln] = 1'b1;
			end else begin
				for (int i = 0; i < NEAR_WORDS; i++)
					mem_words[(va + i) % MEM_WORDS] = vb[i];
			end
		end
		n_data[ln] = blk;
		n_tag[ln] = a / (NEAR_WORDS * NEAR_SETS);
		n_val[ln] = 1'b1;
		n_dty[ln] = 1'b0;
		near_touch(s, way, was_valid);
	endfunction

	// fill the far level; a dirty victim goes to memory
	function automatic void far_fill(int a);
		int s, b, way, ln, va, fb;
		bit was_valid;
		s = (a / FAR_WORDS) % FAR_SETS;
		b = s * FAR_WAYS;
		way = pick_way(b, FAR_WAYS, 1'b0);
		ln = b + way;
		was_valid = f_val[ln];
		fb = a - a % FAR_WORDS;
		if (was_valid && f_dty[ln]) begin
			va = f_tag[ln] * FAR_WORDS * FAR_SETS + s * FAR_WORDS;
			// memory words are read before the victim is written back
			for (int i = 0; i < FAR_WORDS; i++) begin
				logic [DATA_W-1:0] t;
				t = mem_words[(fb + i) % MEM_WORDS];
				mem_words[(va + i) % MEM_WORDS] = f_data[ln][i];
				f_data[ln][i] = t;
			end
		end else begin
			for (int i = 0; i < FAR_WORDS; i++)
				f_data[ln][i] = mem_words[(fb + i) % MEM_WORDS];
		end
		f_tag[ln] = a / (FAR_WORDS * FAR_SETS);
		f_val[ln] = 1'b1;
		f_dty[ln] = 1'b0;
		far_touch(s, way, was_valid);
	endfunction

	// predicted response of one request, updating the model
	function automatic rsp_t cache_access(req_t r);
		rsp_t o;
		int a, w, s, ln, nb;
		logic [DATA_W-1:0] blk [NEAR_WORDS];
		o = '0;
		a = int'(r.word_address);
		if (r.operation[OP_FLUSH_BIT]) begin
			for (int l = 0; l < F_LINES; l++)
				if (f_val[l] && f_dty[l])
					for (int i = 0; i < FAR_WORDS; i++)
						mem_words[(f_tag[l]*FAR_WORDS*FAR_SETS + (l/FAR_WAYS)*FAR_WORDS + i)
							% MEM_WORDS] = f_data[l][i];
			for (int l = 0; l < N_LINES; l++)
				if (n_val[l] && n_dty[l])
					for (int i = 0; i < NEAR_WORDS; i++)
						mem_words[(n_tag[l]*NEAR_WORDS*NEAR_SETS + (l/NEAR_WAYS)*NEAR_WORDS + i)
							% MEM_WORDS] = n_data[l][i];
			o.served_by = SRV_FLUSH;
			return o;
		end
		w = near_find(a);
		if (w >= 0) begin
			s = (a / NEAR_WORDS) % NEAR_SETS;
			ln = s * NEAR_WAYS + w;
			near_touch(s, w, 1'b1);
			if (r.operation == OP_WRITE) begin
				n_data[ln][a % NEAR_WORDS] = r.write_data;
				n_dty[ln] = 1'b1;
			end else
				o.read_data = n_data[ln][a % NEAR_WORDS];
			o.served_by = SRV_NEAR;
			o.service_cycles = lat_near;
			return o;
		end
		w = far_find(a);
		if (w >= 0) begin
			s = (a / FAR_WORDS) % FAR_SETS;
			ln = s * FAR_WAYS + w;
			nb = (a - a % NEAR_WORDS) % FAR_WORDS;
			far_touch(s, w, 1'b1);
			if (r.operation == OP_WRITE) begin
				f_data[ln][a % FAR_WORDS] = r.write_data;
				f_dty[ln] = 1'b1;
			end else
				o.read_data = f_data[ln][a % FAR_WORDS];
			for (int i = 0; i < NEAR_WORDS; i++)
				blk[i] = f_data[ln][(nb + i) % FAR_WORDS];
			near_fill(a, blk);
			o.served_by = SRV_FAR;
			o.service_cycles = lat_far;
			return o;
		end
		if (r.operation == OP_WRITE)
			mem_words[a] = r.write_data;
		nb = a - a % NEAR_WORDS;
		for (int i = 0; i < NEAR_WORDS; i++)
			blk[i] = mem_words[(nb + i) % MEM_WORDS];
		near_fill(a, blk);
		far_fill(a);
		if (r.operation != OP_WRITE)
			o.read_data = mem_words[a];
		o.served_by = SRV_MEM;
		o.service_cycles = lat_mem;
		return o;
	endfunction

	// send one item after a random gap; valid stays high after acceptance
	// until the next item or the drain takes it down
	task automatic send_item(logic [1:0] op, logic [7:0] addr, logic [31:0] data);
		req_t r;
		int gap;
		r.operation = op;
		r.word_address = addr;
		r.write_data = data;
		gap = $urandom_range(0, 3);
		@(negedge clk);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		expected_rsps.push_back(cache_access(r));
		sent++;
	endtask

	// wait for all results, then a quiet pause
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_rsps.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_latency(logic [CFG_IDX_W-1:0] idx, logic [LAT_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_L1_LAT: lat_near = val;
			CFG_L2_LAT: lat_far = val;
			default: lat_mem = val;
		endcase
	endtask

	// random stall on the response side, drawn while a result is valid
	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
			if (rsp_valid && $urandom_range(0, 3) == 0)
				stall_left <= $urandom_range(1, 3);
		end
	end

	// check each accepted result
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			got++;
			if (expected_rsps.size() == 0) begin
				$error("unexpected result item %h", rsp);
				errors++;
			end else begin
				e = expected_rsps.pop_front();
				srv_count[rsp.served_by]++;
				if (rsp.read_data !== e.read_data) begin
					$error("read_data exp %h got %h", e.read_data, rsp.read_data);
					errors++;
				end
				if (rsp.served_by !== e.served_by) begin
					$error("served_by exp %0d got %0d", e.served_by, rsp.served_by);
					errors++;
				end
				if (rsp.service_cycles !== e.service_cycles) begin
					$error("service_cycles exp %0d got %0d", e.service_cycles,
						rsp.service_cycles);
					errors++;
				end
			end
		end
	end

	// extremes of fields, every operation, flush code three
	task automatic test_directed();
		send_item(OP_READ, 8'd0, 32'h0);
		send_item(OP_WRITE, 8'd255, 32'hFFFF_FFFF);
		send_item(OP_READ, 8'd255, 32'h0);
		send_item(OP_WRITE, 8'd0, 32'h8000_0000);
		send_item(OP_WRITE, 8'd1, 32'h7FFF_FFFF);
		send_item(OP_READ, 8'd0, 32'hFFFF_FFFF);
		send_item(OP_FLUSH, 8'd77, 32'h1234_5678);
		send_item(OP_FLUSH_ALT, 8'd200, 32'hDEAD_BEEF);
		// same near set, different tags: evict dirty near lines
		for (int i = 0; i < 6; i++)
			send_item(OP_WRITE, 8'(i * 16 + 2), 32'hA5A5_0000 + i);
		for (int i = 0; i < 6; i++)
			send_item(OP_READ, 8'(i * 16 + 2), 32'h0);
		send_item(OP_FLUSH, 8'd0, 32'h0);
		drain();
	endtask

	// random items, optionally over a narrow address pool to force conflicts
	task automatic test_random(int n, bit narrow);
		logic [1:0] op;
		logic [7:0] addr;
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			op = pick < 45 ? OP_READ : pick < 94 ? OP_WRITE : pick < 97 ? OP_FLUSH : OP_FLUSH_ALT;
			addr = 8'($urandom);
			if (narrow)
				addr = {addr[7:5] & 3'b011, 2'b00, addr[2:0]} | (addr[4] ? 8'h10 : 8'h00);
			send_item(op, addr, $urandom);
		end
		drain();
	endtask

	// latency registers through extremes and random values
	task automatic test_latency_settings();
		write_latency(CFG_L1_LAT, 8'd0);
		write_latency(CFG_L2_LAT, 8'd255);
		write_latency(CFG_MEM_LAT, 8'd0);
		test_random(300, 1'b1);
		write_latency(CFG_L1_LAT, 8'd255);
		write_latency(CFG_L2_LAT, 8'd0);
		write_latency(CFG_MEM_LAT, 8'd255);
		test_random(300, 1'b0);
		write_latency(CFG_L1_LAT, 8'($urandom));
		write_latency(CFG_L2_LAT, 8'($urandom));
		write_latency(CFG_MEM_LAT, 8'($urandom));
		test_random(500, 1'b1);
	endtask

	initial begin
		for (int i = 0; i < MEM_WORDS; i++) mem_words[i] = '0;
		for (int i = 0; i < N_LINES; i++) begin
			n_val[i] = 0; n_dty[i] = 0; n_rank[i] = 0; n_tag[i] = 0;
		end
		for (int i = 0; i < F_LINES; i++) begin
			f_val[i] = 0; f_dty[i] = 0; f_rank[i] = 0; f_tag[i] = 0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(580, 1'b1);
		test_latency_settings();
		$display("covered %0d requests: %0d near hits, %0d far hits, %0d memory, %0d flushes",
			sent, srv_count[0], srv_count[1], srv_count[2], srv_count[3]);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// guard against a hang
	initial begin
		#20000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
